FILE: rtl/slsc_pkg.sv
// Shared types, constants and helper functions of the string literal scanner.
package slsc_pkg;

    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 16;
    localparam int OFFSET_BITS = 24;
    localparam int QUEUE_DEPTH = 3;

    typedef logic [LINE_BITS-1:0]   t_line;
    typedef logic [COLUMN_BITS-1:0] t_column;
    typedef logic [OFFSET_BITS-1:0] t_offset;

    localparam logic [7:0] CH_BACKTICK = 8'h60;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_LOWER_N  = 8'h6E;
    localparam logic [7:0] CH_LOWER_T  = 8'h74;
    localparam logic [7:0] CH_LOWER_R  = 8'h72;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_TOKEN = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_CHAR_LEN   = 2'd1,
        ERR_LINE_BREAK = 2'd2,
        ERR_NOT_CLOSED = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_text;
        t_line      first_line;
        t_column    first_column;
        t_offset    first_offset;
    } t_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value_byte;
        t_err       error_code;
        logic [7:0] quote_byte;
        t_line      line_no;
        t_column    column_from;
        t_column    column_to;
        t_offset    offset_from;
        t_offset    offset_to;
        t_line      next_line;
        logic       last;
    } t_result;

    typedef struct packed {
        logic       active;
        logic       esc;
        logic [7:0] quote;
        logic [1:0] count;
        t_line      cur_line;
        t_column    cur_column;
        t_offset    cur_offset;
        t_line      beg_line;
        t_column    beg_column;
        t_offset    beg_offset;
    } t_state;

    localparam t_state STATE_RESET = '{
        active:     1'b0,
        esc:        1'b0,
        quote:      8'h00,
        count:      2'd0,
        cur_line:   t_line'(1),
        cur_column: t_column'(1),
        cur_offset: '0,
        beg_line:   t_line'(1),
        beg_column: t_column'(1),
        beg_offset: '0
    };

    function automatic t_line inc_line(input t_line v);
        return (v == '1) ? v : v + t_line'(1);
    endfunction

    function automatic t_column inc_column(input t_column v);
        return (v == '1) ? v : v + t_column'(1);
    endfunction

    function automatic t_offset inc_offset(input t_offset v);
        return (v == '1) ? v : v + t_offset'(1);
    endfunction

endpackage

FILE: rtl/slsc_if.sv
// Valid/ready channel interfaces for scanner input items and result items.
interface slsc_in_if;
    logic                    valid;
    logic                    ready;
    logic [7:0]              char_byte;
    logic                    end_of_text;
    slsc_pkg::t_line         first_line;
    slsc_pkg::t_column       first_column;
    slsc_pkg::t_offset       first_offset;

    modport source (output valid, char_byte, end_of_text, first_line, first_column,
                    first_offset, input ready);
    modport sink (input valid, char_byte, end_of_text, first_line, first_column,
                  first_offset, output ready);
endinterface

interface slsc_out_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              result_kind;
    logic [7:0]              value_byte;
    logic [1:0]              error_code;
    logic [7:0]              quote_byte;
    slsc_pkg::t_line         line_no;
    slsc_pkg::t_column       column_from;
    slsc_pkg::t_column       column_to;
    slsc_pkg::t_offset       offset_from;
    slsc_pkg::t_offset       offset_to;
    slsc_pkg::t_line         next_line;
    logic                    last;

    modport source (output valid, result_kind, value_byte, error_code, quote_byte, line_no,
                     column_from, column_to, offset_from, offset_to, next_line, last,
                     input ready);
    modport sink (input valid, result_kind, value_byte, error_code, quote_byte, line_no,
                  column_from, column_to, offset_from, offset_to, next_line, last,
                  output ready);
endinterface

FILE: rtl/slsc_step.sv
// Next-state and result logic for one scanned byte.
module slsc_step (
    input  slsc_pkg::t_state  i_state,
    input  slsc_pkg::t_item   i_item,
    output slsc_pkg::t_state  o_state,
    output logic [1:0]        o_count,
    output slsc_pkg::t_result o_res0,
    output slsc_pkg::t_result o_res1
);

    slsc_pkg::t_state  st;
    slsc_pkg::t_result r0;
    slsc_pkg::t_result r1;
    logic [1:0]        cnt;
    logic [7:0]        c;
    logic [7:0]        dec;
    logic              known;

    always_comb begin
        st    = i_state;
        cnt   = 2'd0;
        r0    = '0;
        r1    = '0;
        c     = i_item.char_byte;
        dec   = c;
        known = 1'b1;
        r0.quote_byte = i_state.quote;
        r1.quote_byte = i_state.quote;

        case (c)
            slsc_pkg::CH_LOWER_N:  dec = slsc_pkg::CH_NEWLINE;
            slsc_pkg::CH_LOWER_T:  dec = slsc_pkg::CH_TAB;
            slsc_pkg::CH_LOWER_R:  dec = slsc_pkg::CH_CR;
            slsc_pkg::CH_ZERO:     dec = slsc_pkg::CH_NUL;
            slsc_pkg::CH_BSLASH:   dec = slsc_pkg::CH_BSLASH;
            slsc_pkg::CH_SQUOTE:   dec = slsc_pkg::CH_SQUOTE;
            slsc_pkg::CH_DQUOTE:   dec = slsc_pkg::CH_DQUOTE;
            slsc_pkg::CH_BACKTICK: dec = slsc_pkg::CH_BACKTICK;
            default:               known = 1'b0;
        endcase

        if (!i_state.active) begin
            if (!i_item.end_of_text) begin
                st.active     = 1'b1;
                st.esc        = 1'b0;
                st.count      = 2'd0;
                st.quote      = c;
                st.beg_line   = i_item.first_line;
                st.beg_column = i_item.first_column;
                st.beg_offset = i_item.first_offset;
                st.cur_line   = i_item.first_line;
                st.cur_column = slsc_pkg::inc_column(i_item.first_column);
                st.cur_offset = slsc_pkg::inc_offset(i_item.first_offset);
            end
        end else if (i_item.end_of_text) begin
            cnt            = 2'd1;
            r0.kind        = slsc_pkg::KIND_ERROR;
            r0.error_code  = slsc_pkg::ERR_NOT_CLOSED;
            r0.line_no     = i_state.beg_line;
            r0.column_from = i_state.beg_column;
            r0.column_to   = slsc_pkg::inc_column(i_state.beg_column);
            r0.offset_from = i_state.beg_offset;
            r0.offset_to   = i_state.cur_offset;
            r0.next_line   = i_state.cur_line;
            st.active      = 1'b0;
            st.esc         = 1'b0;
            st.count       = 2'd0;
        end else if (i_state.esc) begin
            if (!known) begin
                cnt           = 2'd2;
                r0.kind       = slsc_pkg::KIND_BYTE;
                r0.value_byte = slsc_pkg::CH_BSLASH;
                r1.kind       = slsc_pkg::KIND_BYTE;
                r1.value_byte = dec;
                st.count      = 2'd2;
            end else begin
                cnt           = 2'd1;
                r0.kind       = slsc_pkg::KIND_BYTE;
                r0.value_byte = dec;
                st.count      = (i_state.count == 2'd0) ? 2'd1 : 2'd2;
            end
            st.esc        = 1'b0;
            st.cur_column = slsc_pkg::inc_column(i_state.cur_column);
            st.cur_offset = slsc_pkg::inc_offset(i_state.cur_offset);
        end else if (c == slsc_pkg::CH_BSLASH) begin
            st.esc        = 1'b1;
            st.cur_column = slsc_pkg::inc_column(i_state.cur_column);
            st.cur_offset = slsc_pkg::inc_offset(i_state.cur_offset);
        end else if (c == i_state.quote) begin
            cnt            = 2'd1;
            st.cur_column  = slsc_pkg::inc_column(i_state.cur_column);
            st.cur_offset  = slsc_pkg::inc_offset(i_state.cur_offset);
            if (i_state.quote == slsc_pkg::CH_SQUOTE && i_state.count != 2'd1) begin
                r0.kind       = slsc_pkg::KIND_ERROR;
                r0.error_code = slsc_pkg::ERR_CHAR_LEN;
            end else begin
                r0.kind       = slsc_pkg::KIND_TOKEN;
                r0.error_code = slsc_pkg::ERR_NONE;
            end
            r0.line_no     = i_state.beg_line;
            r0.column_from = i_state.beg_column;
            r0.column_to   = st.cur_column;
            r0.offset_from = i_state.beg_offset;
            r0.offset_to   = st.cur_offset;
            r0.next_line   = i_state.cur_line;
            st.active      = 1'b0;
            st.esc         = 1'b0;
            st.count       = 2'd0;
        end else if (c == slsc_pkg::CH_NEWLINE && i_state.quote != slsc_pkg::CH_BACKTICK) begin
            cnt            = 2'd1;
            r0.kind        = slsc_pkg::KIND_ERROR;
            r0.error_code  = slsc_pkg::ERR_LINE_BREAK;
            r0.line_no     = i_state.cur_line;
            r0.column_from = i_state.cur_column;
            r0.column_to   = slsc_pkg::inc_column(i_state.cur_column);
            r0.offset_from = i_state.beg_offset;
            r0.offset_to   = i_state.cur_offset;
            r0.next_line   = i_state.cur_line;
            st.active      = 1'b0;
            st.esc         = 1'b0;
            st.count       = 2'd0;
        end else begin
            cnt           = 2'd1;
            r0.kind       = slsc_pkg::KIND_BYTE;
            r0.value_byte = c;
            st.count      = (i_state.count == 2'd0) ? 2'd1 : 2'd2;
            st.cur_offset = slsc_pkg::inc_offset(i_state.cur_offset);
            if (c == slsc_pkg::CH_NEWLINE) begin
                st.cur_line   = slsc_pkg::inc_line(i_state.cur_line);
                st.cur_column = slsc_pkg::t_column'(1);
            end else begin
                st.cur_column = slsc_pkg::inc_column(i_state.cur_column);
            end
        end

        r0.last = (cnt == 2'd1);
        r1.last = (cnt == 2'd2);
    end

    assign o_state = st;
    assign o_count = cnt;
    assign o_res0  = r0;
    assign o_res1  = r1;

endmodule

FILE: rtl/slsc_outq.sv
// Three-entry result queue; takes up to two results per cycle, gives one.
module slsc_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_n,
    input  slsc_pkg::t_result i_res0,
    input  slsc_pkg::t_result i_res1,
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_room,
    output slsc_pkg::t_result o_head
);

    slsc_pkg::t_result r_q [slsc_pkg::QUEUE_DEPTH];
    logic [1:0]        r_head;
    logic [1:0]        r_count;
    logic [1:0]        n_head;
    logic [1:0]        n_count;
    logic [1:0]        w0;
    logic [1:0]        w1;
    logic              pop;

    function automatic logic [1:0] wrap3(input logic [2:0] x);
        return (x >= 3'(slsc_pkg::QUEUE_DEPTH)) ? 2'(x - 3'(slsc_pkg::QUEUE_DEPTH)) : x[1:0];
    endfunction

    assign pop     = i_pop && (r_count != 2'd0);
    assign o_valid = (r_count != 2'd0);
    assign o_room  = (r_count <= 2'd1) || (r_count == 2'd2 && pop);
    assign o_head  = r_q[r_head];
    assign w0      = wrap3(3'(r_head) + 3'(r_count));
    assign w1      = wrap3(3'(r_head) + 3'(r_count) + 3'd1);

    always_comb begin
        n_head  = pop ? wrap3(3'(r_head) + 3'd1) : r_head;
        n_count = r_count + i_push_n - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 2'd0;
            r_count <= 2'd0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_q[w0] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_q[w1] <= i_res1;
        end
    end

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |-> o_room)
        else $error("result pushed without room");

    a_head_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < 2'(slsc_pkg::QUEUE_DEPTH))
        else $error("queue head out of range");

endmodule

FILE: rtl/string_literal_scanner.sv
// Top level of the string literal scanner.
// Scans one text byte per input transfer and sustains one byte per clock cycle.
// Each accepted byte is decoded in the cycle it is taken; its results are
// registered in a three-entry result queue and leave from its head. An unknown
// escape yields two decoded bytes and so two output transfers; the input is
// ready whenever at least two queue entries are free after the current output
// transfer, so a long run of unknown escapes (or a stalled sink) slows input to
// the output rate. No clearing pass after reset.
module string_literal_scanner (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slsc_in_if.sink      i_in,
    slsc_out_if.source   o_out
);

    slsc_pkg::t_state  r_state;
    slsc_pkg::t_state  n_state;
    slsc_pkg::t_item   item;
    slsc_pkg::t_result res0;
    slsc_pkg::t_result res1;
    slsc_pkg::t_result head;
    logic [1:0]        res_n;
    logic [1:0]        push_n;
    logic              accept;
    logic              room;
    logic              q_valid;

    assign item = '{
        char_byte:    i_in.char_byte,
        end_of_text:  i_in.end_of_text,
        first_line:   i_in.first_line,
        first_column: i_in.first_column,
        first_offset: i_in.first_offset
    };

    assign i_in.ready = room;
    assign accept     = i_in.valid && room;
    assign push_n     = accept ? res_n : 2'd0;

    slsc_step u_step (
        .i_state (r_state),
        .i_item  (item),
        .o_state (n_state),
        .o_count (res_n),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slsc_pkg::STATE_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    slsc_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_res0   (res0),
        .i_res1   (res1),
        .i_pop    (o_out.ready),
        .o_valid  (q_valid),
        .o_room   (room),
        .o_head   (head)
    );

    assign o_out.valid       = q_valid;
    assign o_out.result_kind = head.kind;
    assign o_out.value_byte  = head.value_byte;
    assign o_out.error_code  = head.error_code;
    assign o_out.quote_byte  = head.quote_byte;
    assign o_out.line_no     = head.line_no;
    assign o_out.column_from = head.column_from;
    assign o_out.column_to   = head.column_to;
    assign o_out.offset_from = head.offset_from;
    assign o_out.offset_to   = head.offset_to;
    assign o_out.next_line   = head.next_line;
    assign o_out.last        = head.last;

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_state.active) |-> (res_n == 2'd0))
        else $error("result produced from idle state");

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && res_n == 2'd1 && res0.kind != slsc_pkg::KIND_BYTE) |=> !r_state.active)
        else $error("scanner stayed inside literal after token or error");

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_n == 2'd2) |-> (res1.last && !res0.last && res0.value_byte == slsc_pkg::CH_BSLASH))
        else $error("bad two-byte escape results");

endmodule
